FILE: rtl/k_medoids_pam_cluster_top_defines.svh
// assertion macros of the top-level rtl file
`ifndef K_MEDOIDS_PAM_CLUSTER_TOP_DEFINES_SVH
`define K_MEDOIDS_PAM_CLUSTER_TOP_DEFINES_SVH

// same-cycle implication on clk, idle in reset
`define KMP_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication on clk, idle in reset
`define KMP_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: rtl/kmp_pkg.sv
// shared types and constants of the k-medoids cluster block
`default_nettype none
package kmp_pkg;
	localparam int DEF_MAX_POINTS   = 256;
	localparam int DEF_MAX_DIMS     = 8;
	localparam int DEF_MAX_CLUSTERS = 8;

	localparam int COORD_W = 16;
	localparam int LOSS_W  = 26;
	localparam logic [LOSS_W-1:0] LOSS_MAX = 26'h3FF_FFFF;

	localparam logic [1:0] CFG_NUM_CLUSTERS   = 2'd0;
	localparam logic [1:0] CFG_MAX_ITERATIONS = 2'd1;
	localparam logic [1:0] CFG_NUM_DIMS       = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_FILL, S_INIT, S_CAND, S_PT, S_SEL, S_RD, S_SQ, S_AC,
		S_SQRT, S_MIN, S_CEND, S_APPLY, S_OUT
	} state_t;

	typedef enum logic [1:0] {
		M_BUILD, M_SWAP, M_FINAL
	} mode_t;
endpackage
`default_nettype wire

FILE: rtl/k_medoids_pam_cluster_top.sv
// k-medoids (pam build and swap) clustering block, top level
//
// channel   direction  handshake                 payload
// command   in         start && !busy            coord, end_of_point, end_of_set
// config    in         cfg_valid && cfg_ready    cfg_index, cfg_data
// result    out        valid (one cycle each)    medoid_slot, medoid_index, total_loss, last
//
// loading stores each coordinate as it is transferred; closing a point with fewer than MAX_DIMS
//   coordinates zero-fills the rest of that point's store entry while busy is high
// clustering reuses one distance unit: each distance steps through select, then per coordinate
//   a two-port point store read, one 17x17 squarer and an add, then one root digit per cycle, min
// build needs about nc*n*n*(nc+1)/2 distances, each swap pass nc*n*n*nc, then n*nc
// results follow back to back, one per medoid slot; busy drops after the last one
// async reset clears control and medoids and sets the config registers to their defaults;
// the point store needs no clear; the receiver cannot stall, so every result transfer completes in its cycle
`default_nettype none
module k_medoids_pam_cluster_top #(
	parameter int MAX_POINTS   = kmp_pkg::DEF_MAX_POINTS,
	parameter int MAX_DIMS     = kmp_pkg::DEF_MAX_DIMS,
	parameter int MAX_CLUSTERS = kmp_pkg::DEF_MAX_CLUSTERS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// command channel
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic signed [15:0]          coord,
	input  wire logic                        end_of_point,
	input  wire logic                        end_of_set,
	// configuration channel
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [7:0]                  cfg_data,
	// result channel
	output logic                             valid,
	output logic [2:0]                       medoid_slot,
	output logic [7:0]                       medoid_index,
	output logic [25:0]                      total_loss,
	output logic                             last
);
	`include "k_medoids_pam_cluster_top_defines.svh"

	// widths derived from the size parameters
	localparam int PW     = $clog2(MAX_POINTS);              // point index
	localparam int NW     = PW + 1;                          // point count
	localparam int DBITS  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int NDW    = $clog2(MAX_DIMS + 1);            // dimension count
	localparam int CW     = $clog2(MAX_CLUSTERS + 1);        // cluster count
	localparam int MIW    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int SUMW   = 32 + $clog2(MAX_DIMS);           // squared distance sum
	localparam int SW     = ((SUMW + 1) / 2) * 2;
	localparam int DIST_W = SW / 2;                          // root width
	localparam int RW     = DIST_W + 2;                      // root remainder
	localparam int ITW    = $clog2(DIST_W);
	localparam int TW     = DIST_W + NW;                     // candidate total
	localparam int LW     = (TW > kmp_pkg::LOSS_W) ? TW : kmp_pkg::LOSS_W;
	localparam int XW     = (PW > 8) ? PW : 8;
	localparam int AW     = PW + DBITS;
	localparam int DEPTH  = MAX_POINTS << DBITS;

	kmp_pkg::state_t state_q, state_d;
	kmp_pkg::mode_t  mode_q;

	// configuration registers
	logic [3:0] num_clusters_q;
	logic [7:0] max_iterations_q;
	logic [3:0] num_dims_q;

	// loading
	logic [NW-1:0]  pc_q;
	logic [NDW-1:0] cc_q;
	logic           eos_q;

	// loop counters and running values
	logic [NW-1:0]     i_q, j_q, best_q;
	logic [CW-1:0]     k_q, m_q, slot_q;
	logic [MIW-1:0]    bslot_q;
	logic [NDW-1:0]    d_q;
	logic [7:0]        pass_q;
	logic              ph_i_q, cinf_q, have_q;
	logic [DIST_W-1:0] c_q;
	logic [TW-1:0]     tot_q, best_tot_q;
	logic [kmp_pkg::LOSS_W-1:0] loss_q;
	logic [PW-1:0]     med_q [MAX_CLUSTERS];

	// distance unit
	logic [PW-1:0]        a_q;
	logic [SW-1:0]        acc_q, rad_q;
	logic [31:0]          sq_q;
	logic [RW-1:0]        rem_q;
	logic [DIST_W-1:0]    root_q;
	logic [ITW-1:0]       it_q;
	logic [15:0]          rda_s1, rdb_s1;
	logic [15:0]          mem [DEPTH];

	// clamped registers
	logic [NDW-1:0] nd_c;
	logic [CW-1:0]  nc_c;
	always_comb begin
		if (num_dims_q == 4'd0) nd_c = NDW'(1);
		else if (num_dims_q > MAX_DIMS) nd_c = NDW'(MAX_DIMS);
		else nd_c = NDW'(num_dims_q);
		if (num_clusters_q == 4'd0) nc_c = CW'(1);
		else if (num_clusters_q > MAX_CLUSTERS) nc_c = CW'(MAX_CLUSTERS);
		else nc_c = CW'(num_clusters_q);
	end

	logic accept;
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// coordinate count after this transfer, saturating
	logic [NDW-1:0] cc_next;
	assign cc_next = (cc_q < NDW'(MAX_DIMS)) ? cc_q + NDW'(1) : cc_q;
	logic room;
	assign room = pc_q < NW'(MAX_POINTS);

	// point store write port
	logic          we;
	logic [AW-1:0] waddr;
	logic [15:0]   wdata;
	always_comb begin
		we    = 1'b0;
		waddr = {pc_q[PW-1:0], d_q[DBITS-1:0]};
		wdata = 16'd0;
		if (state_q == kmp_pkg::S_IDLE) begin
			we    = accept && (cc_q < nd_c) && room;
			waddr = {pc_q[PW-1:0], cc_q[DBITS-1:0]};
			wdata = coord;
		end else if (state_q == kmp_pkg::S_FILL) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rda_s1 <= mem[{a_q, d_q[DBITS-1:0]}];
		rdb_s1 <= mem[{j_q[PW-1:0], d_q[DBITS-1:0]}];
	end

	// single medoid read port
	logic [MIW-1:0] med_ra;
	logic [PW-1:0]  med_rd;
	always_comb begin
		unique case (state_q)
			kmp_pkg::S_APPLY: med_ra = bslot_q;
			kmp_pkg::S_OUT:   med_ra = slot_q[MIW-1:0];
			default:          med_ra = m_q[MIW-1:0];
		endcase
	end
	assign med_rd = med_q[med_ra];

	// squarer
	logic signed [16:0] diff;
	logic signed [33:0] prod;
	assign diff = {rda_s1[15], rda_s1} - {rdb_s1[15], rdb_s1};
	assign prod = diff * diff;

	// one root digit per cycle
	logic [RW-1:0]     rem_sh, trial;
	logic              fits;
	assign rem_sh = {rem_q[RW-3:0], rad_q[SW-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	// candidate comparison and loop limits
	logic [CW-1:0] lim;
	logic          incl, better;
	logic [TW-1:0] tot_add;
	logic [LW-1:0] tot_ext;
	assign lim     = (mode_q == kmp_pkg::M_BUILD) ? k_q : nc_c;
	assign incl    = (mode_q != kmp_pkg::M_SWAP) || (m_q != k_q);
	assign better  = !have_q || (tot_q < best_tot_q);
	assign tot_add = tot_q + TW'(c_q);
	assign tot_ext = LW'(tot_q);

	// next state and outputs
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kmp_pkg::S_IDLE: begin
				if (accept && (end_of_point || end_of_set)) begin
					if (room && (cc_next < NDW'(MAX_DIMS))) state_d = kmp_pkg::S_FILL;
					else if (end_of_set) state_d = kmp_pkg::S_INIT;
				end
			end
			kmp_pkg::S_FILL: begin
				if (d_q == NDW'(MAX_DIMS - 1))
					state_d = eos_q ? kmp_pkg::S_INIT : kmp_pkg::S_IDLE;
			end
			kmp_pkg::S_INIT: state_d = (pc_q == '0) ? kmp_pkg::S_OUT : kmp_pkg::S_CAND;
			kmp_pkg::S_CAND: state_d = kmp_pkg::S_PT;
			kmp_pkg::S_PT:   state_d = kmp_pkg::S_SEL;
			kmp_pkg::S_SEL: begin
				if (ph_i_q) state_d = kmp_pkg::S_RD;
				else if (m_q < lim) state_d = incl ? kmp_pkg::S_RD : kmp_pkg::S_SEL;
				else if (j_q + NW'(1) == pc_q) state_d = kmp_pkg::S_CEND;
				else state_d = kmp_pkg::S_PT;
			end
			kmp_pkg::S_RD:   state_d = kmp_pkg::S_SQ;
			kmp_pkg::S_SQ:   state_d = kmp_pkg::S_AC;
			kmp_pkg::S_AC:   state_d = (d_q + NDW'(1) == nd_c) ? kmp_pkg::S_SQRT : kmp_pkg::S_RD;
			kmp_pkg::S_SQRT: state_d = (it_q == ITW'(DIST_W - 1)) ? kmp_pkg::S_MIN : kmp_pkg::S_SQRT;
			kmp_pkg::S_MIN:  state_d = kmp_pkg::S_SEL;
			kmp_pkg::S_CEND: begin
				priority case (mode_q)
					kmp_pkg::M_FINAL: state_d = kmp_pkg::S_OUT;
					kmp_pkg::M_SWAP:
						if ((i_q + NW'(1) == pc_q) && (k_q + CW'(1) == nc_c))
							state_d = kmp_pkg::S_APPLY;
						else state_d = kmp_pkg::S_CAND;
					default: state_d = kmp_pkg::S_CAND;
				endcase
			end
			kmp_pkg::S_APPLY: state_d = kmp_pkg::S_CAND;
			kmp_pkg::S_OUT:   if (slot_q + CW'(1) == nc_c) state_d = kmp_pkg::S_IDLE;
			default:          state_d = kmp_pkg::S_IDLE;
		endcase

		busy        = state_q != kmp_pkg::S_IDLE;
		valid       = state_q == kmp_pkg::S_OUT;
		medoid_slot = slot_q[2:0];
		medoid_index = 8'(XW'(med_rd));
		total_loss  = loss_q;
		last        = valid && (slot_q + CW'(1) == nc_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= kmp_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_clusters_q   <= 4'd2;
			max_iterations_q <= 8'd10;
			num_dims_q       <= 4'd2;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				kmp_pkg::CFG_NUM_CLUSTERS:   num_clusters_q   <= cfg_data[3:0];
				kmp_pkg::CFG_MAX_ITERATIONS: max_iterations_q <= cfg_data;
				kmp_pkg::CFG_NUM_DIMS:       num_dims_q       <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// loading control and medoid store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			cc_q    <= '0;
			eos_q   <= 1'b0;
			mode_q  <= kmp_pkg::M_BUILD;
			k_q     <= '0;
			slot_q  <= '0;
			have_q  <= 1'b0;
			pass_q  <= '0;
			for (int n = 0; n < MAX_CLUSTERS; n++) med_q[n] <= '0;
		end else begin
			unique case (state_q)
				kmp_pkg::S_IDLE: begin
					if (accept) begin
						eos_q <= end_of_set;
						if (end_of_point || end_of_set) begin
							cc_q <= '0;
							if (room && (cc_next >= NDW'(MAX_DIMS))) pc_q <= pc_q + NW'(1);
						end else begin
							cc_q <= cc_next;
						end
					end
				end
				kmp_pkg::S_FILL: begin
					if (d_q == NDW'(MAX_DIMS - 1)) begin
						pc_q <= pc_q + NW'(1);
						cc_q <= '0;
					end
				end
				kmp_pkg::S_INIT: begin
					for (int n = 0; n < MAX_CLUSTERS; n++) med_q[n] <= '0;
					mode_q <= kmp_pkg::M_BUILD;
					k_q    <= '0;
					have_q <= 1'b0;
					slot_q <= '0;
				end
				kmp_pkg::S_CEND: begin
					priority case (mode_q)
						kmp_pkg::M_BUILD: begin
							if (i_q + NW'(1) == pc_q) begin
								med_q[k_q[MIW-1:0]] <= better ? i_q[PW-1:0] : best_q[PW-1:0];
								have_q <= 1'b0;
								if (k_q + CW'(1) == nc_c) begin
									k_q    <= '0;
									pass_q <= '0;
									mode_q <= (max_iterations_q == 8'd0) ?
										kmp_pkg::M_FINAL : kmp_pkg::M_SWAP;
								end else begin
									k_q <= k_q + CW'(1);
								end
							end else if (better) begin
								have_q <= 1'b1;
							end
						end
						kmp_pkg::M_SWAP: begin
							if (better) have_q <= 1'b1;
							if ((i_q + NW'(1) == pc_q) && (k_q + CW'(1) != nc_c))
								k_q <= k_q + CW'(1);
						end
						default: slot_q <= '0;
					endcase
				end
				kmp_pkg::S_APPLY: begin
					med_q[bslot_q] <= best_q[PW-1:0];
					pass_q <= pass_q + 8'd1;
					k_q    <= '0;
					have_q <= 1'b0;
					if ((med_rd == best_q[PW-1:0]) ||
					    ({1'b0, pass_q} + 9'd1 == {1'b0, max_iterations_q}))
						mode_q <= kmp_pkg::M_FINAL;
				end
				kmp_pkg::S_OUT: begin
					if (slot_q + CW'(1) == nc_c) begin
						pc_q <= '0;
						cc_q <= '0;
					end else begin
						slot_q <= slot_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// candidate loops and distance unit datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			kmp_pkg::S_IDLE: d_q <= cc_next;
			kmp_pkg::S_FILL: d_q <= d_q + NDW'(1);
			kmp_pkg::S_INIT: begin
				i_q    <= '0;
				loss_q <= '0;
			end
			kmp_pkg::S_CAND: begin
				tot_q <= '0;
				j_q   <= '0;
			end
			kmp_pkg::S_PT: begin
				cinf_q <= 1'b1;
				ph_i_q <= mode_q != kmp_pkg::M_FINAL;
				m_q    <= '0;
			end
			kmp_pkg::S_SEL: begin
				acc_q <= '0;
				d_q   <= '0;
				if (ph_i_q) begin
					a_q    <= i_q[PW-1:0];
					ph_i_q <= 1'b0;
				end else if (m_q < lim) begin
					a_q <= med_rd;
					m_q <= m_q + CW'(1);
				end else begin
					tot_q <= tot_add;
					j_q   <= j_q + NW'(1);
				end
			end
			kmp_pkg::S_SQ: sq_q <= prod[31:0];
			kmp_pkg::S_AC: begin
				acc_q  <= acc_q + SW'(sq_q);
				d_q    <= d_q + NDW'(1);
				rad_q  <= acc_q + SW'(sq_q);
				rem_q  <= '0;
				root_q <= '0;
				it_q   <= '0;
			end
			kmp_pkg::S_SQRT: begin
				rad_q  <= {rad_q[SW-3:0], 2'b00};
				rem_q  <= fits ? rem_sh - trial : rem_sh;
				root_q <= {root_q[DIST_W-2:0], fits};
				it_q   <= it_q + ITW'(1);
			end
			kmp_pkg::S_MIN: begin
				d_q <= '0;
				if (cinf_q || (root_q < c_q)) begin
					c_q    <= root_q;
					cinf_q <= 1'b0;
				end
			end
			kmp_pkg::S_CEND: begin
				if (better && (mode_q != kmp_pkg::M_FINAL)) begin
					best_q     <= i_q;
					best_tot_q <= tot_q;
					if (mode_q == kmp_pkg::M_SWAP) bslot_q <= k_q[MIW-1:0];
				end
				if (mode_q == kmp_pkg::M_FINAL)
					loss_q <= (tot_ext > LW'(kmp_pkg::LOSS_MAX)) ?
						kmp_pkg::LOSS_MAX : tot_ext[kmp_pkg::LOSS_W-1:0];
				i_q <= (i_q + NW'(1) == pc_q) ? '0 : i_q + NW'(1);
			end
			kmp_pkg::S_APPLY: i_q <= '0;
			default: ;
		endcase
	end

	// a result always comes with the block busy
	`KMP_ASSERT_NOW(a_valid_busy, valid, busy, "result strobe while idle")
	// the final result hands the block back
	`KMP_ASSERT_NEXT(a_last_idle, valid && last, !busy, "busy after final result")
	// results of one set follow back to back
	`KMP_ASSERT_NEXT(a_out_run, valid && !last, valid, "gap between results")
	// a closing transfer of a set starts the run
	`KMP_ASSERT_NEXT(a_set_busy, start && !busy && end_of_set, busy, "set closed but idle")
endmodule
`default_nettype wire

FILE: tb/tb.sv
// self-checking testbench of the k-medoids cluster block with its own clustering predictor
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS     = kmp_pkg::DEF_MAX_POINTS;
	localparam int NDIM     = kmp_pkg::DEF_MAX_DIMS;
	localparam int NCLU     = kmp_pkg::DEF_MAX_CLUSTERS;
	// eight clusters over three points of eight coordinates give the longest swap pass, with up to
	// 255 passes, so the limit is sized for that longest silent run
	localparam int WD_LIMIT = 40000000;
	localparam int N_RANDOM = 140;
	localparam int MAX_REPORT = 10;

	// one coordinate transfer on the command channel
	typedef struct {
		logic signed [15:0] c;
		logic               eop;
		logic               eos;
	} coord_item_t;

	// one medoid result
	typedef struct {
		logic [2:0]  slot;
		logic [7:0]  index;
		logic [25:0] loss;
		logic        last;
	} medoid_res_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [15:0] coord;
	logic               end_of_point;
	logic               end_of_set;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [7:0]         cfg_data;
	logic               valid;
	logic [2:0]         medoid_slot;
	logic [7:0]         medoid_index;
	logic [25:0]        total_loss;
	logic               last;

	k_medoids_pam_cluster_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.coord        (coord),
		.end_of_point (end_of_point),
		.end_of_set   (end_of_set),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.valid        (valid),
		.medoid_slot  (medoid_slot),
		.medoid_index (medoid_index),
		.total_loss   (total_loss),
		.last         (last)
	);

	// clock: 2 ns high, 2 ns low
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// ---------------------------------------------------------------
	// predictor state: its own copy of the registers and stores
	// ---------------------------------------------------------------
	logic signed [15:0] pt_mem [NPTS][NDIM];
	int                 pt_cnt;
	int                 crd_cnt;
	logic [3:0]         reg_nc;
	logic [7:0]         reg_iters;
	logic [3:0]         reg_nd;
	int unsigned        dist_mat [NPTS][NPTS];
	int unsigned        medoids [NCLU];
	int unsigned        nearest_other [NPTS];

	medoid_res_t  medoid_q [$];   // expected results, oldest first
	coord_item_t  coord_q [$];    // coordinates waiting for the driver

	int  items_pushed;
	int  items_taken;
	int  errors;
	int  quiet_cycles;
	bit  taken;       // the command at the last rising edge was a transfer
	bit  idle_en;     // random gaps on the command side
	int  gap_left;
	int  gen_nd;      // coordinates per point as the block will use them
	int  gen_nc;

	function automatic int clamp_reg(logic [3:0] v, int hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : int'(v);
	endfunction

	// floor square root, one result bit at a time from the top
	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic int unsigned pt_distance(int a, int b, int nd);
		longint unsigned acc;
		longint          diff;
		acc = 0;
		for (int d = 0; d < nd; d++) begin
			diff = longint'(pt_mem[a][d]) - longint'(pt_mem[b][d]);
			acc += longint'(diff * diff);
		end
		return int'(root_floor(acc));
	endfunction

	// build then swap over the stored set, queue one result per medoid slot
	function automatic void cluster_set();
		int              n;
		int              nd;
		int              nc;
		int unsigned     c;
		int unsigned     prev [NCLU];
		longint unsigned tot;
		longint unsigned best_tot;
		longint unsigned loss;
		int              best;
		int              slot;
		bit              have;
		bit              same;
		medoid_res_t     r;
		n  = pt_cnt;
		nd = clamp_reg(reg_nd, NDIM);
		nc = clamp_reg(reg_nc, NCLU);
		for (int m = 0; m < NCLU; m++)
			medoids[m] = 0;
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				dist_mat[i][j] = pt_distance(i, j, nd);
		// build: greedy, one slot at a time
		for (int k = 0; k < nc; k++) begin
			best = 0;
			best_tot = 0;
			have = 0;
			for (int i = 0; i < n; i++) begin
				tot = 0;
				for (int j = 0; j < n; j++) begin
					c = dist_mat[i][j];
					for (int m = 0; m < k; m++)
						if (dist_mat[medoids[m]][j] < c)
							c = dist_mat[medoids[m]][j];
					tot += c;
				end
				if (!have || tot < best_tot) begin
					have = 1;
					best_tot = tot;
					best = i;
				end
			end
			medoids[k] = best;
		end
		// swap passes: the best slot and candidate pairing is always applied
		for (int pass = 0; pass < int'(reg_iters); pass++) begin
			prev = medoids;
			best = 0;
			slot = 0;
			best_tot = 0;
			have = 0;
			for (int k = 0; k < nc; k++) begin
				for (int j = 0; j < n; j++) begin
					c = 32'hFFFF_FFFF;
					for (int m = 0; m < nc; m++)
						if (m != k && dist_mat[medoids[m]][j] < c)
							c = dist_mat[medoids[m]][j];
					nearest_other[j] = c;
				end
				for (int i = 0; i < n; i++) begin
					tot = 0;
					for (int j = 0; j < n; j++)
						tot += (dist_mat[i][j] < nearest_other[j]) ?
							dist_mat[i][j] : nearest_other[j];
					if (!have || tot < best_tot) begin
						have = 1;
						best_tot = tot;
						best = i;
						slot = k;
					end
				end
			end
			medoids[slot] = best;
			same = 1;
			for (int m = 0; m < NCLU; m++)
				if (prev[m] != medoids[m])
					same = 0;
			if (same)
				break;
		end
		loss = 0;
		for (int j = 0; j < n; j++) begin
			c = 32'hFFFF_FFFF;
			for (int m = 0; m < nc; m++)
				if (dist_mat[medoids[m]][j] < c)
					c = dist_mat[medoids[m]][j];
			loss += c;
		end
		if (loss > longint'(kmp_pkg::LOSS_MAX))
			loss = longint'(kmp_pkg::LOSS_MAX);
		for (int k = 0; k < nc; k++) begin
			r.slot  = k[2:0];
			r.index = medoids[k][7:0];
			r.loss  = loss[25:0];
			r.last  = (k + 1 == nc);
			medoid_q.push_back(r);
		end
	endfunction

	// one accepted coordinate: store it, close the point, cluster on end of set
	function automatic void take_coord(logic signed [15:0] c, logic eop, logic eos);
		int nd;
		nd = clamp_reg(reg_nd, NDIM);
		if (crd_cnt < nd && pt_cnt < NPTS)
			pt_mem[pt_cnt][crd_cnt] = c;
		if (crd_cnt < NDIM)
			crd_cnt++;
		if (eop || eos) begin
			// missing coordinates of a short point read as zero
			if (pt_cnt < NPTS) begin
				for (int d = crd_cnt; d < NDIM; d++)
					pt_mem[pt_cnt][d] = '0;
				pt_cnt++;
			end
			crd_cnt = 0;
		end
		if (eos) begin
			cluster_set();
			pt_cnt = 0;
			crd_cnt = 0;
		end
	endfunction

	// ---------------------------------------------------------------
	// monitor: transfers at the rising edge, result checks, watchdog
	// ---------------------------------------------------------------
	always @(posedge clk) begin : mon
		medoid_res_t exp_r;
		bit          active;
		active = 0;
		taken <= start && !busy;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				active = 1;
				case (cfg_index)
					kmp_pkg::CFG_NUM_CLUSTERS:   reg_nc    = cfg_data[3:0];
					kmp_pkg::CFG_MAX_ITERATIONS: reg_iters = cfg_data;
					kmp_pkg::CFG_NUM_DIMS:       reg_nd    = cfg_data[3:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				active = 1;
				items_taken++;
				take_coord(coord, end_of_point, end_of_set);
			end
			if (valid) begin
				active = 1;
				if (medoid_q.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORT)
						$display("unexpected result: slot %0d index %0d loss %0d last %0b",
							medoid_slot, medoid_index, total_loss, last);
				end else begin
					exp_r = medoid_q.pop_front();
					if (medoid_slot !== exp_r.slot || medoid_index !== exp_r.index ||
							total_loss !== exp_r.loss || last !== exp_r.last) begin
						errors++;
						if (errors <= MAX_REPORT)
							$display("mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
								exp_r.slot, exp_r.index, exp_r.loss, exp_r.last,
								medoid_slot, medoid_index, total_loss, last);
					end
				end
			end
			// clustering is long and silent, so the limit is generous
			if (active)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WD_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// driver: feeds coordinates from the queue at the falling edge
	// ---------------------------------------------------------------
	always @(negedge clk) begin : drv
		coord_item_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !taken) begin
			// transfer still pending, hold the item
		end else if (gap_left > 0) begin
			gap_left--;
			start <= 1'b0;
		end else if (coord_q.size() != 0) begin
			if (idle_en && $urandom_range(0, 5) == 0) begin
				gap_left = $urandom_range(0, 15);
				start <= 1'b0;
			end else begin
				nxt = coord_q.pop_front();
				start        <= 1'b1;
				coord        <= nxt.c;
				end_of_point <= nxt.eop;
				end_of_set   <= nxt.eos;
			end
		end else begin
			start <= 1'b0;
		end
	end

	task automatic push_coord(logic signed [15:0] c, logic eop, logic eos);
		coord_item_t it;
		it.c   = c;
		it.eop = eop;
		it.eos = eos;
		coord_q.push_back(it);
		items_pushed++;
	endtask

	// register write, only while the block is idle
	task automatic write_reg(logic [1:0] idx, logic [7:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(logic [7:0] nc, logic [7:0] iters, logic [7:0] nd);
		write_reg(kmp_pkg::CFG_NUM_CLUSTERS, nc);
		write_reg(kmp_pkg::CFG_MAX_ITERATIONS, iters);
		write_reg(kmp_pkg::CFG_NUM_DIMS, nd);
		gen_nc = clamp_reg(nc[3:0], NCLU);
		gen_nd = clamp_reg(nd[3:0], NDIM);
	endtask

	// every coordinate transferred, every result in, block idle, then a short pause
	task automatic wait_drained();
		do
			@(negedge clk);
		while (items_taken != items_pushed || busy || medoid_q.size() != 0);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic signed [15:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'($urandom_range(0, 16) - 8);             // small, gives ties
			3: return 16'($urandom_range(0, 400) - 200);
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// one point set; most are well formed, a few have short or long points
	task automatic gen_set(int n_pts);
		bit clean;
		int ncrd;
		clean = ($urandom_range(0, 6) != 0);
		for (int p = 0; p < n_pts; p++) begin
			ncrd = clean ? gen_nd : $urandom_range(1, 11);
			for (int d = 0; d < ncrd; d++) begin
				if (d == ncrd - 1)
					push_coord(pick_coord(), (p == n_pts - 1) ? 1'($urandom_range(0, 1)) : 1'b1,
						p == n_pts - 1);
				else
					push_coord(pick_coord(), 1'b0, 1'b0);
			end
		end
	endtask

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	initial begin
		int base;
		int npts;
		arst_n       = 1'b0;
		start        = 1'b0;
		coord        = '0;
		end_of_point = 1'b0;
		end_of_set   = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = kmp_pkg::CFG_NUM_CLUSTERS;
		cfg_data     = '0;
		pt_cnt       = 0;
		crd_cnt      = 0;
		reg_nc       = 4'd2;
		reg_iters    = 8'd10;
		reg_nd       = 4'd2;
		items_pushed = 0;
		items_taken  = 0;
		errors       = 0;
		quiet_cycles = 0;
		gap_left     = 0;
		idle_en      = 1'b1;
		gen_nc       = 2;
		gen_nd       = 2;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings, coordinate extremes
		push_coord(16'sh8000, 1'b1, 1'b0);
		push_coord(16'sh8000, 1'b1, 1'b0);
		push_coord(16'sh7FFF, 1'b0, 1'b0);
		push_coord(16'sh7FFF, 1'b1, 1'b0);
		push_coord(16'sh0000, 1'b0, 1'b0);
		push_coord(16'sh0000, 1'b1, 1'b0);
		push_coord(16'sh0001, 1'b0, 1'b0);
		push_coord(-16'sh0001, 1'b1, 1'b1);
		wait_drained();

		// more clusters than points, no swap pass, extra coordinates ignored
		set_config(8'h08, 8'h00, 8'h01);
		for (int d = 0; d < 9; d++)
			push_coord(16'(5 + d), 1'b0, 1'b0);
		push_coord(16'sh1234, 1'b1, 1'b0);
		push_coord(-16'sh0003, 1'b0, 1'b1);
		wait_drained();

		// out-of-range registers clamp, short points zero filled
		set_config(8'hF0, 8'hFF, 8'h0F);
		push_coord(16'sh0100, 1'b0, 1'b0);
		push_coord(-16'sh0100, 1'b1, 1'b0);
		for (int d = 0; d < 4; d++)
			push_coord(16'(16 * d), d == 3, 1'b0);
		push_coord(16'sh7000, 1'b0, 1'b1);
		wait_drained();

		// upper clamp of the cluster count, lower clamp of the dimensions
		set_config(8'h0F, 8'hFF, 8'h00);
		gen_set(3);
		wait_drained();

		// random sets under random settings; the last part runs without gaps
		base = items_pushed;
		while (items_pushed - base < N_RANDOM) begin
			idle_en = (items_pushed - base < (3 * N_RANDOM) / 4) && ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 5) == 0)
				set_config(8'($urandom_range(5, 8)), 8'($urandom_range(0, 255)),
					8'($urandom_range(1, 8)));
			else
				set_config(8'($urandom_range(1, 4)),
					8'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 3) :
						$urandom_range(0, 255)),
					8'($urandom_range(0, 15)));
			npts = (gen_nc > 4) ? $urandom_range(1, 3) : $urandom_range(1, 4);
			gen_set(npts);
			wait_drained();
		end

		repeat (50) @(negedge clk);
		if (errors == 0 && medoid_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
